/* hdl/siad_pkg.sv */
// package: types, codes and constants of the signed alu with divide
`timescale 1ns / 1ps
package siad_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_REM_ZERO = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] left_operand;
        logic signed [31:0] right_operand;
    } alu_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status_code;
    } alu_out_t;

    // control carried alongside a division
    typedef struct packed {
        logic       is_div;
        logic       neg_quot;
        logic       neg_rem;
        logic       zero_div;
    } div_ctl_t;

endpackage

/* hdl/signed_integer_alu_with_divide_core.sv */
// top level: pipelined signed alu with add, subtract, multiply, divide, remainder
`timescale 1ns / 1ps
// Usage: raise start with a request on in; it is taken when busy is low.
// busy is tied low, so one transfer can be taken every clock cycle.
// Every request gives exactly one result on out, marked by done for one
// cycle, in request order. From the accepting edge a request passes through
// one input register, a magnitude register, the divider input register,
// ceil(DATA_WIDTH/DIV_STEPS) divider stages (four at the defaults) and the
// output register, which also applies the signs. Add, subtract and multiply
// results are delayed to match. Division or remainder by zero gives 0 with
// its own status; unknown codes give 0 with the unknown status. The
// receiver cannot stall: done is a strobe and the result must be taken in
// that cycle. Reset clears all valid bits, so no result appears until
// requests are accepted after reset.
module signed_integer_alu_with_divide_core
    import siad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int DIV_STEPS  = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_in_t  in,
    output logic     done,
    output alu_out_t out
);
    localparam int NST     = (DATA_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int MID     = NST + 1;
    localparam int LATENCY = MID + 3;

    logic                  v0_reg;
    logic [2:0]            op0_reg;
    logic [DATA_WIDTH-1:0] a0_reg, b0_reg;

    logic [MID:0]          v_reg;
    logic [2:0]            op_reg [MID+1];
    logic [DATA_WIDTH-1:0] as_reg [MID+1];
    div_ctl_t              ctl_reg [MID+1];

    logic [DATA_WIDTH-1:0] mag_a, mag_b, prod, quot, rem;
    logic [DATA_WIDTH-1:0] mag_a_reg, mag_b_reg;
    logic                  out_v_reg;
    alu_out_t              out_reg, out_next;
    logic [DATA_WIDTH-1:0] res_w;
    logic [1:0]            st_w;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg    <= 1'b0;
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else begin
            v0_reg    <= start && !busy;
            v_reg     <= {v_reg[MID-1:0], v0_reg};
            out_v_reg <= v_reg[MID];
        end
    end

    always_ff @(posedge clk)
    begin
        op0_reg <= in.operation;
        a0_reg  <= DATA_WIDTH'(in.left_operand);
        b0_reg  <= DATA_WIDTH'(in.right_operand);
    end

    // magnitudes feed the divider; sum or difference is kept in the side line
    assign mag_a = a0_reg[DATA_WIDTH-1] ? -a0_reg : a0_reg;
    assign mag_b = b0_reg[DATA_WIDTH-1] ? -b0_reg : b0_reg;

    always_ff @(posedge clk)
    begin
        mag_a_reg          <= mag_a;
        mag_b_reg          <= mag_b;
        op_reg[0]          <= op0_reg;
        as_reg[0]          <= (op0_reg == OP_SUB) ? a0_reg - b0_reg : a0_reg + b0_reg;
        ctl_reg[0].is_div   <= (op0_reg == OP_DIV);
        ctl_reg[0].neg_quot <= a0_reg[DATA_WIDTH-1] ^ b0_reg[DATA_WIDTH-1];
        ctl_reg[0].neg_rem  <= a0_reg[DATA_WIDTH-1];
        ctl_reg[0].zero_div <= (b0_reg == '0);
        for (int i = 1; i <= MID; i++) begin
            op_reg[i]  <= op_reg[i-1];
            as_reg[i]  <= as_reg[i-1];
            ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    siad_div #(.DATA_WIDTH(DATA_WIDTH), .STEPS(DIV_STEPS)) u_div (
        .clk      (clk),
        .dividend (mag_a_reg),
        .divisor  (mag_b_reg),
        .quot     (quot),
        .rem      (rem)
    );

    siad_mul #(.DATA_WIDTH(DATA_WIDTH), .LATENCY(MID + 1)) u_mul (
        .clk (clk),
        .a   (a0_reg),
        .b   (b0_reg),
        .p   (prod)
    );

    always_comb
    begin
        res_w = '0;
        st_w  = ST_OK;
        case (op_reg[MID])
            OP_ADD, OP_SUB: res_w = as_reg[MID];
            OP_MUL:         res_w = prod;
            OP_DIV:
            begin
                if (ctl_reg[MID].zero_div) st_w = ST_DIV_ZERO;
                else res_w = ctl_reg[MID].neg_quot ? -quot : quot;
            end
            OP_REM:
            begin
                if (ctl_reg[MID].zero_div) st_w = ST_REM_ZERO;
                else res_w = ctl_reg[MID].neg_rem ? -rem : rem;
            end
            default:        st_w = ST_UNKNOWN;
        endcase
        out_next.result_value = 32'(res_w);
        out_next.status_code  = st_w;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done = out_v_reg;
    assign out  = out_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |-> ##(LATENCY-1) done)
        else $error("result lost in pipeline");
    a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[MID] |-> ctl_reg[MID].is_div == (op_reg[MID] == OP_DIV))
        else $error("divide flag mismatch");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out.status_code != ST_OK |-> out.result_value == '0)
        else $error("error status with nonzero result");
endmodule

/* hdl/siad_mul.sv */
// pipelined multiplier: low word of the product, split in two halves
`timescale 1ns / 1ps
module siad_mul
    import siad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int LATENCY    = 4
)
(
    input  logic                  clk,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] p
);
    localparam int H  = DATA_WIDTH / 2;
    localparam int HH = DATA_WIDTH - H;

    logic [DATA_WIDTH-1:0] ll_reg, lh_reg, hl_reg;
    logic [DATA_WIDTH-1:0] sum_reg;
    logic [DATA_WIDTH-1:0] dly_reg [LATENCY-2];

    always_ff @(posedge clk)
    begin
        ll_reg  <= DATA_WIDTH'({{HH{1'b0}}, a[H-1:0]} * {{HH{1'b0}}, b[H-1:0]});
        lh_reg  <= DATA_WIDTH'({{H{1'b0}}, a[DATA_WIDTH-1:H]} * {{HH{1'b0}}, b[H-1:0]});
        hl_reg  <= DATA_WIDTH'({{HH{1'b0}}, a[H-1:0]} * {{H{1'b0}}, b[DATA_WIDTH-1:H]});
        sum_reg <= ll_reg + ((lh_reg + hl_reg) << H);
        dly_reg[0] <= sum_reg;
        for (int i = 1; i < LATENCY - 2; i++)
            dly_reg[i] <= dly_reg[i-1];
    end

    assign p = dly_reg[LATENCY-3];
endmodule

/* hdl/siad_div.sv */
// pipelined unsigned restoring divider, STEPS quotient bits per stage
`timescale 1ns / 1ps
module siad_div
    import siad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int STEPS      = 8
)
(
    input  logic                  clk,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] quot,
    output logic [DATA_WIDTH-1:0] rem
);
    localparam int NST = (DATA_WIDTH + STEPS - 1) / STEPS;

    logic [DATA_WIDTH-1:0] q_reg [NST+1];
    logic [DATA_WIDTH-1:0] r_reg [NST+1];
    logic [DATA_WIDTH-1:0] d_reg [NST+1];

    always_ff @(posedge clk)
    begin
        q_reg[0] <= dividend;
        r_reg[0] <= '0;
        d_reg[0] <= divisor;
    end

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [DATA_WIDTH-1:0] q_next, r_next;
        always_comb
        begin
            logic [DATA_WIDTH:0] t;
            q_next = q_reg[s];
            r_next = r_reg[s];
            for (int k = 0; k < STEPS; k++) begin
                if (s * STEPS + k < DATA_WIDTH) begin
                    t = {r_next, q_next[DATA_WIDTH-1]};
                    q_next = q_next << 1;
                    if (t >= {1'b0, d_reg[s]}) begin
                        t = t - {1'b0, d_reg[s]};
                        q_next[0] = 1'b1;
                    end
                    r_next = t[DATA_WIDTH-1:0];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            q_reg[s+1] <= q_next;
            r_reg[s+1] <= r_next;
            d_reg[s+1] <= d_reg[s];
        end
    end

    assign quot = q_reg[NST];
    assign rem  = r_reg[NST];
endmodule

/* sim/tb_signed_integer_alu_with_divide_core.sv */
// testbench: signed alu with divide, directed and random operations checked against a predictor
`timescale 1ns / 1ps
module tb_signed_integer_alu_with_divide_core;
    import siad_pkg::*;

    localparam int LATENCY_GUESS = 16;
    localparam int CYCLE_LIMIT   = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    alu_in_t  in;
    logic     done;
    alu_out_t out;

    alu_out_t expected_results[$];
    int       error_count;
    int       cycle_count;
    bit       quiet_mode;

    signed_integer_alu_with_divide_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .in    (in),
        .done  (done),
        .out   (out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic alu_out_t compute_alu(alu_in_t req);
        alu_out_t   r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        a = req.left_operand;
        b = req.right_operand;
        r.result_value = '0;
        r.status_code  = ST_OK;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (req.operation)
            OP_ADD: r.result_value = a + b;
            OP_SUB: r.result_value = a - b;
            OP_MUL: r.result_value = a * b;
            OP_DIV:
                if (b == 0)
                    r.status_code = ST_DIV_ZERO;
                else
                begin
                    q = ma / mb;
                    r.result_value = (a[31] != b[31]) ? -q : q;
                end
            OP_REM:
                if (b == 0)
                    r.status_code = ST_REM_ZERO;
                else
                begin
                    q = ma % mb;
                    r.result_value = a[31] ? -q : q;
                end
            default: r.status_code = ST_UNKNOWN;
        endcase
        return r;
    endfunction

    task automatic send_operation(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        alu_in_t req;
        req.operation     = op;
        req.left_operand  = a;
        req.right_operand = b;
        while (!quiet_mode && $urandom_range(99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in    <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(compute_alu(req));
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(3) - 1;
            3: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[6];
        edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd7};
        for (int op = OP_ADD; op <= OP_REM; op++)
            for (int k = 0; k < 4; k++)
                send_operation(3'(op), edges[k + 2], edges[(k + 3) % 6]);
        send_operation(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_operation(OP_REM, 32'h8000_0000, 32'hffff_ffff);
        send_operation(OP_DIV, 32'hffff_fff9, 32'd0);
        send_operation(OP_REM, 32'd7, 32'd0);
        send_operation(3'd5, 32'd1, 32'd1);
        send_operation(3'd7, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_operation(3'($urandom_range(7)), random_operand(), random_operand());
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        alu_out_t expected;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h", $time, out);
                error_count++;
            end
            else
            begin
                expected = expected_results.pop_front();
                if (out.result_value !== expected.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, expected.result_value, out.result_value);
                    error_count++;
                end
                if (out.status_code !== expected.status_code)
                begin
                    $display("%0t: status_code expected %0d actual %0d",
                             $time, expected.status_code, out.status_code);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        in          = '0;
        error_count = 0;
        cycle_count = 0;
        quiet_mode  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        wait_drained();
        quiet_mode = 1'b1;
        test_random(400);
        quiet_mode = 1'b0;
        test_random(620);
        wait_drained();
        repeat (LATENCY_GUESS) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
